// ----- hw/rtl/paged_char_lcd_refresher_macros.svh -----
// Assertion macros for the paged character-LCD refresher.
// Every use expects a clock named clk and a reset named rst in scope.
`ifndef PAGED_CHAR_LCD_REFRESHER_MACROS_SVH
`define PAGED_CHAR_LCD_REFRESHER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PCLR_ASSERT(LBL, PROP, MSG) \
  LBL: assert property (@(posedge clk) disable iff (rst) (PROP)) else $error(MSG);

// Consequence that must hold in the cycle after the condition.
`define PCLR_ASSERT_NEXT(LBL, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge clk) disable iff (rst) (ANTE) |=> (CONS)) else $error(MSG);

`endif

// ----- hw/rtl/pclr_pkg.sv -----
// Shared types and constants for the paged character-LCD refresher.
// No dependencies.
package pclr_pkg;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_WRITE_CHAR  = 3'd1,
    CMD_SET_ENABLE  = 3'd2,
    CMD_ONLY_PAGE   = 3'd3,
    CMD_FORCE_PAGE  = 3'd4,
    CMD_CLEAR_TEXT  = 3'd5,
    CMD_DISABLE_ALL = 3'd6
  } cmd_t;

  localparam int CMD_W      = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // LCD constants
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_SPACE     = 8'h20;
  localparam int         ROW_STRIDE    = 40;

endpackage

// ----- hw/rtl/pclr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pclr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/paged_char_lcd_refresher.sv -----
// A character tick passes MUL_ROW, MUL_COL, ACCESS and EMIT; a row-address command passes
// ROWCMD and EMIT; an end-of-page command or timer restart goes straight to EMIT. Any wait on
// m_tready holds EMIT. A write char passes MUL_ROW, MUL_COL and ACCESS and gives no result;
// a page search walks up to PAGES pages in SEARCH. A new request is taken only in IDLE.
// Reset and clear-content run a fill pass over all PAGES*ROWS*COLS entries (256 at
// defaults) writing spaces into the text RAM; s_tready stays low meanwhile.
`include "paged_char_lcd_refresher_macros.svh"

// Top level: request decode, sequencer, shared multiply-add and output register.
// Depends on pclr_pkg, pclr_ram and the assertion macro header.
module paged_char_lcd_refresher #(
  parameter int PAGES = 8,
  parameter int ROWS  = 2,
  parameter int COLS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // config: page_hold_seconds
  input  logic                              cfg_wr_en,
  input  logic [7:0]                        cfg_wr_data,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] page, [4:3] row, [10:5] column, [18:11] char_code, [19] enable_value,
  // [20] display_busy, [21] page_timer_expired, [23:22] zero
  input  logic [pclr_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [2:0] command
  input  logic [pclr_pkg::CMD_W-1:0]        s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] write_valid, [8:1] lcd_byte, [9] restart_timer, [17:10] timer_reload,
  // [23:18] zero
  output logic [pclr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // [0] is_data
  output logic                              m_tuser
);

  localparam int DEPTH = PAGES * ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLS + 1);
  localparam int MACW  = (AW > 8) ? AW : 8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SEARCH, ST_MUL_ROW, ST_MUL_COL, ST_ACCESS, ST_ROWCMD, ST_EMIT
  } state_t;

  // what the pending result is built from
  typedef enum logic [1:0] {SRC_RAM, SRC_MAC, SRC_PAGE_END, SRC_RESTART} res_src_t;

  state_t     state;
  res_src_t   res_src;

  // block state
  logic [PAGES-1:0] enabled;
  logic [PW-1:0]    shown_page;
  logic [RW-1:0]    refresh_row;
  logic [CW-1:0]    refresh_col;
  logic             pending;
  logic [7:0]       hold_seconds;

  // sequencer working registers
  logic [AW-1:0]    clr_addr;
  logic [PW-1:0]    srch_cnt;
  logic             go_search;
  logic             is_write;
  logic [PW-1:0]    addr_page;
  logic [RW-1:0]    addr_row;
  logic [CW-1:0]    addr_col;
  logic [7:0]       item_char;
  logic [MACW-1:0]  mac_out;

  // output register
  logic             out_wv;
  logic [7:0]       out_byte;
  logic             out_is_data;
  logic             out_restart;
  logic [7:0]       out_reload;

  // request fields
  pclr_pkg::cmd_t   in_cmd;
  logic [31:0]      in_page_w, in_row_w, in_col_w;
  logic [PW-1:0]    in_page;
  logic [RW-1:0]    in_row;
  logic [CW-1:0]    in_col;
  logic [7:0]       in_char;
  logic             in_enable, in_busy, in_expired;
  logic             accept;

  assign in_cmd     = pclr_pkg::cmd_t'(s_tuser);
  assign in_page_w  = 32'(s_tdata[2:0]);
  assign in_row_w   = 32'(s_tdata[4:3]);
  assign in_col_w   = 32'(s_tdata[10:5]);
  assign in_char    = s_tdata[18:11];
  assign in_enable  = s_tdata[19];
  assign in_busy    = s_tdata[20];
  assign in_expired = s_tdata[21];

  // saturate to the last valid entry
  assign in_page = (in_page_w >= 32'(PAGES)) ? PW'(PAGES - 1) : PW'(in_page_w);
  assign in_row  = (in_row_w >= 32'(ROWS)) ? RW'(ROWS - 1) : RW'(in_row_w);
  assign in_col  = (in_col_w >= 32'(COLS)) ? CW'(COLS - 1) : CW'(in_col_w);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // round-robin page step used by the search walk
  logic [PW-1:0] next_page;
  logic          search_done;
  assign next_page   = (shown_page == PW'(PAGES - 1)) ? '0 : shown_page + 1'b1;
  assign search_done = enabled[next_page] || (srch_cnt == PW'(PAGES - 1));

  // next row for the end-of-row address command
  logic [RW:0] row_inc;
  assign row_inc = {1'b0, refresh_row} + 1'b1;

  // end-of-page tick consumes a pending switch; forcing an enabled page or only-page drops it too
  logic at_page_end, drop_pending;
  assign at_page_end  = (in_cmd == pclr_pkg::CMD_TICK) && enabled[shown_page] && !in_busy
                     && (refresh_col >= CW'(COLS)) && (row_inc >= (RW + 1)'(ROWS));
  assign drop_pending = at_page_end || (in_cmd == pclr_pkg::CMD_ONLY_PAGE)
                     || ((in_cmd == pclr_pkg::CMD_FORCE_PAGE) && enabled[in_page]);

  // shared multiply-add: page*ROWS+row, then *COLS+col, or row*40
  logic [MACW-1:0] mac_a, mac_k, mac_b;
  logic            mac_en;

  always_comb begin
    mac_a  = '0;
    mac_k  = '0;
    mac_b  = '0;
    mac_en = 1'b0;
    unique case (state)
      ST_MUL_ROW: begin
        mac_a  = MACW'(addr_page);
        mac_k  = MACW'(ROWS);
        mac_b  = MACW'(addr_row);
        mac_en = 1'b1;
      end
      ST_MUL_COL: begin
        mac_a  = mac_out;
        mac_k  = MACW'(COLS);
        mac_b  = MACW'(addr_col);
        mac_en = 1'b1;
      end
      ST_ROWCMD: begin
        mac_a  = MACW'(refresh_row);
        mac_k  = MACW'(pclr_pkg::ROW_STRIDE);
        mac_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mac_en) begin
      mac_out <= mac_a * mac_k + mac_b;
    end
  end

  // text RAM: fill pass writes spaces, write-char stores, tick reads
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata, ram_rdata;

  assign ram_we    = (state == ST_CLEAR) || ((state == ST_ACCESS) && is_write);
  assign ram_re    = (state == ST_ACCESS) && !is_write;
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : mac_out[AW-1:0];
  assign ram_wdata = (state == ST_CLEAR) ? pclr_pkg::LCD_SPACE : item_char;

  pclr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mac_out[AW-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      srch_cnt     <= '0;
      go_search    <= 1'b0;
      enabled      <= '0;
      shown_page   <= '0;
      refresh_row  <= '0;
      refresh_col  <= '0;
      pending      <= 1'b0;
      hold_seconds <= 8'd5;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hold_seconds <= cfg_wr_data;
      end
      // in EMIT a taken result is replaced in the same cycle
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // a timer pulse counts at once; forcing or a page end consumes it
            pending   <= drop_pending ? 1'b0 : (pending | in_expired);
            go_search <= at_page_end && (pending || in_expired);
            srch_cnt  <= '0;
            unique case (in_cmd)
              pclr_pkg::CMD_TICK: begin
                priority if (!enabled[shown_page]) begin
                  state <= ST_SEARCH;
                end else if (in_busy) begin
                  state <= ST_IDLE;
                end else if (refresh_col < CW'(COLS)) begin
                  addr_page   <= shown_page;
                  addr_row    <= refresh_row;
                  addr_col    <= refresh_col;
                  refresh_col <= refresh_col + 1'b1;
                  is_write    <= 1'b0;
                  res_src     <= SRC_RAM;
                  state       <= ST_MUL_ROW;
                end else if (row_inc < (RW + 1)'(ROWS)) begin
                  refresh_col <= '0;
                  refresh_row <= row_inc[RW-1:0];
                  res_src     <= SRC_MAC;
                  state       <= ST_ROWCMD;
                end else begin
                  // end of page: home address, then switch if one is pending
                  refresh_col <= '0;
                  refresh_row <= '0;
                  res_src     <= SRC_PAGE_END;
                  state       <= ST_EMIT;
                end
              end
              pclr_pkg::CMD_WRITE_CHAR: begin
                addr_page <= in_page;
                addr_row  <= in_row;
                addr_col  <= in_col;
                item_char <= in_char;
                is_write  <= 1'b1;
                state     <= ST_MUL_ROW;
              end
              pclr_pkg::CMD_SET_ENABLE: begin
                enabled[in_page] <= in_enable;
              end
              pclr_pkg::CMD_ONLY_PAGE: begin
                enabled    <= PAGES'(1) << in_page;
                shown_page <= in_page;
                res_src    <= SRC_RESTART;
                state      <= ST_EMIT;
              end
              pclr_pkg::CMD_FORCE_PAGE: begin
                if (enabled[in_page]) begin
                  shown_page <= in_page;
                  res_src    <= SRC_RESTART;
                  state      <= ST_EMIT;
                end
              end
              pclr_pkg::CMD_CLEAR_TEXT: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              pclr_pkg::CMD_DISABLE_ALL: begin
                enabled <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_SEARCH: begin
          shown_page <= next_page;
          srch_cnt   <= srch_cnt + 1'b1;
          if (search_done) begin
            state <= ST_IDLE;
          end
        end

        ST_MUL_ROW: state <= ST_MUL_COL;
        ST_MUL_COL: state <= ST_ACCESS;
        ST_ACCESS:  state <= is_write ? ST_IDLE : ST_EMIT;
        ST_ROWCMD:  state <= ST_EMIT;

        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            unique case (res_src)
              SRC_RAM: begin
                out_wv      <= 1'b1;
                out_byte    <= ram_rdata;
                out_is_data <= 1'b1;
                out_restart <= 1'b0;
                out_reload  <= '0;
              end
              SRC_MAC: begin
                out_wv      <= 1'b1;
                out_byte    <= pclr_pkg::LCD_SET_DDRAM | {1'b0, mac_out[6:0]};
                out_is_data <= 1'b0;
                out_restart <= 1'b0;
                out_reload  <= '0;
              end
              SRC_PAGE_END: begin
                out_wv      <= 1'b1;
                out_byte    <= pclr_pkg::LCD_SET_DDRAM;
                out_is_data <= 1'b0;
                out_restart <= 1'b0;
                out_reload  <= '0;
              end
              SRC_RESTART: begin
                out_wv      <= 1'b0;
                out_byte    <= '0;
                out_is_data <= 1'b0;
                out_restart <= 1'b1;
                out_reload  <= hold_seconds;
              end
            endcase
            state <= go_search ? ST_SEARCH : ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'b0, out_reload, out_restart, out_byte, out_wv};
  assign m_tuser = out_is_data;

  logic emit_restart;
  assign emit_restart = (state == ST_EMIT) && (res_src == SRC_RESTART);

  `PCLR_ASSERT(a_col_range, refresh_col <= CW'(COLS), "refresh column past line end")
  `PCLR_ASSERT(a_page_range, shown_page <= PW'(PAGES - 1), "shown page out of range")
  `PCLR_ASSERT(a_ram_one_port, !(ram_we && ram_re), "text RAM read and written together")
  `PCLR_ASSERT_NEXT(a_restart_clears, emit_restart, !pending, "switch still pending")
  `PCLR_ASSERT(a_out_kind, !(m_tvalid && out_wv && out_restart), "write and restart at once")

endmodule
